// File: rtl/rvmt_pkg.sv
// rvmt_pkg: word types, command codes, state codes and flag positions
// shared by the membership table modules
// no dependencies
package rvmt_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned IndexW = 9;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned StateW = 2;
  localparam int unsigned OutCntW = 16;
  localparam int unsigned FlagW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_ENABLE   = 3'd0,
    CMD_ADD_REMOVE   = 3'd1,
    CMD_SET_HELD     = 3'd2,
    CMD_SET_EXCLUDED = 3'd3,
    CMD_SET_GATE     = 3'd4,
    CMD_QUERY        = 3'd5
  } rvmt_cmd_e;

  typedef enum logic [StateW-1:0] {
    ST_HIDDEN = 2'd0,
    ST_LISTED = 2'd1,
    ST_GREYED = 2'd2
  } rvmt_state_e;

  // bit positions in the stored flag field
  localparam int unsigned FlagHeld = 0;
  localparam int unsigned FlagExcl = 1;
  localparam int unsigned FlagGate = 2;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [IndexW-1:0]        entry_index;
    logic signed [DeltaW-1:0] delta;
    logic                     flag_value;
  } rvmt_in_t;

  typedef struct packed {
    logic [StateW-1:0]         entry_state;
    logic signed [OutCntW-1:0] enable_count;
    logic signed [OutCntW-1:0] remove_count;
    logic                      held;
    logic                      index_valid;
    logic                      count_negative;
  } rvmt_out_t;

  // status from the update unit to the pipeline control
  typedef struct packed {
    logic [StateW-1:0] state;
    logic              negative;
    logic              write;
  } rvmt_upd_status_t;

endpackage

// File: rtl/rvmt_ram.sv
// rvmt_ram: generic single write port, single read port RAM with registered read
// no dependencies; a read at the address being written returns the old word
module rvmt_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rvmt_update.sv
// rvmt_update: modify step of the read-modify-write; applies one command to an
// entry's counts and flags and derives the entry state. depends on rvmt_pkg
module rvmt_update
  import rvmt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic                     flag_value_i,
  input  logic [COUNT_BITS-1:0]    enable_i,
  input  logic [COUNT_BITS-1:0]    remove_i,
  input  logic [FlagW-1:0]         flags_i,
  output logic [COUNT_BITS-1:0]    enable_o,
  output logic [COUNT_BITS-1:0]    remove_o,
  output logic [FlagW-1:0]         flags_o,
  output rvmt_upd_status_t         status_o
);

  logic [COUNT_BITS-1:0] delta_ext;
  logic                  member;
  logic [StateW-1:0]     state;
  logic                  negative;
  logic                  wr_en;

  // delta sign-extended or truncated to the count width
  assign delta_ext = COUNT_BITS'(delta_i);

  always_comb begin
    enable_o = enable_i;
    remove_o = remove_i;
    flags_o  = flags_i;
    negative = 1'b0;
    wr_en    = 1'b1;
    unique case (cmd_i)
      CMD_ADD_ENABLE: begin
        enable_o = enable_i + delta_ext;
        negative = enable_o[COUNT_BITS-1];
      end
      CMD_ADD_REMOVE: begin
        remove_o = remove_i + delta_ext;
        negative = remove_o[COUNT_BITS-1];
      end
      CMD_SET_HELD:     flags_o[FlagHeld] = flag_value_i;
      CMD_SET_EXCLUDED: flags_o[FlagExcl] = flag_value_i;
      CMD_SET_GATE:     flags_o[FlagGate] = flag_value_i;
      default:          wr_en = 1'b0;
    endcase
  end

  assign member = (enable_o != '0) && !enable_o[COUNT_BITS-1] && (remove_o == '0)
                  && !flags_o[FlagHeld] && !flags_o[FlagExcl];

  always_comb begin
    if (!member) begin
      state = ST_HIDDEN;
    end else if (flags_o[FlagGate]) begin
      state = ST_GREYED;
    end else begin
      state = ST_LISTED;
    end
  end

  assign status_o = {state, negative, wr_en};

endmodule

// File: rtl/refcount_veto_membership_table_top.sv
// refcount_veto_membership_table_top: reference-counted membership table with
// veto flags; entry store in rvmt_ram, modify step in rvmt_update, uses rvmt_pkg
//
//  port group   direction  handshake               word
//  in_*         in         in_valid_i / in_stall_o  rvmt_in_t command word
//  out_*        out        out_valid_o / out_stall_i rvmt_out_t result word
//  cfg_*        in         cfg_we_i                entries_in_use (9 bits)
//
// a command goes through a ram read, then modify, write back and result
// register; a new command enters every cycle while in_stall_o is low, a
// back-to-back hit on the same entry is forwarded from the write port
// after reset a clearing pass zeroes every entry of the store, in_stall_o
// stays high until it ends; cfg writes are taken during it
// out_stall_i holds the result register, then the modify stage, then the input
module refcount_veto_membership_table_top
  import rvmt_pkg::*;
#(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rvmt_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rvmt_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [IndexW-1:0] cfg_wdata_i
);

  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WordW = 2 * COUNT_BITS + FlagW;

  logic [IndexW-1:0] entries_q;

  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic          s1_valid_q, s1_valid_d;
  rvmt_in_t      s1_item_q;
  logic          s1_inr_q;
  logic          fwd_hit_q;
  logic [WordW-1:0] fwd_word_q;

  logic          out_valid_q, out_valid_d;
  rvmt_out_t     out_q;

  logic          accept, s1_adv, in_range;
  logic [AW-1:0] in_addr, s1_addr;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WordW-1:0] ram_wdata, ram_rdata, cur_word, new_word;

  logic [COUNT_BITS-1:0] new_enable, new_remove;
  logic [FlagW-1:0]      new_flags;
  rvmt_upd_status_t      upd_status;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  assign in_addr  = AW'(in_data_i.entry_index);
  assign s1_addr  = AW'(s1_item_q.entry_index);
  assign in_range = (in_data_i.entry_index < entries_q)
                    && (32'(in_data_i.entry_index) < 32'(ENTRIES));

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // clearing pass after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      if (clr_addr_q == AW'(ENTRIES - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  // entry store
  rvmt_ram #(
    .WIDTH (WordW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign ram_we    = clr_active_q || (s1_adv && s1_inr_q && upd_status.write);
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_addr;
  assign ram_wdata = clr_active_q ? '0 : new_word;

  // modify stage; forwarded word covers a read that collided with the write
  assign cur_word = fwd_hit_q ? fwd_word_q : ram_rdata;

  rvmt_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .cmd_i        (s1_item_q.command),
    .delta_i      (s1_item_q.delta),
    .flag_value_i (s1_item_q.flag_value),
    .enable_i     (cur_word[COUNT_BITS-1:0]),
    .remove_i     (cur_word[2*COUNT_BITS-1:COUNT_BITS]),
    .flags_i      (cur_word[WordW-1:2*COUNT_BITS]),
    .enable_o     (new_enable),
    .remove_o     (new_remove),
    .flags_o      (new_flags),
    .status_o     (upd_status)
  );

  assign new_word = {new_flags, new_remove, new_enable};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_data_i;
      s1_inr_q   <= in_range;
      fwd_hit_q  <= s1_adv && s1_inr_q && upd_status.write && (s1_addr == in_addr);
      fwd_word_q <= new_word;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_inr_q) begin
        out_q.entry_state    <= upd_status.state;
        out_q.enable_count   <= OutCntW'($signed(new_enable));
        out_q.remove_count   <= OutCntW'($signed(new_remove));
        out_q.held           <= new_flags[FlagHeld];
        out_q.index_valid    <= 1'b1;
        out_q.count_negative <= upd_status.negative;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
